@@ src/aws_pkg.sv @@
// ----------------------------------------------------------------------------
// aws_pkg
// shared types, codes and fixed-point constants of the four-mode waveshaper
// ----------------------------------------------------------------------------
package aws_pkg;

    // default build sizes
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int TABLE_DEPTH_DEF = 256;

    // configuration port
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE = 1'b1;

    // drive and pre-gain
    localparam int GAIN_W = 9;
    localparam logic [GAIN_W-1:0] DRIVE_MAX   = 9'd256;
    localparam logic [GAIN_W-1:0] DRIVE_RESET = 9'd141;
    localparam logic [GAIN_W-1:0] GAIN_BASE   = 9'd64;

    // fixed-point constants
    localparam int Q30_W   = 31;
    localparam int FR_W    = 16;
    localparam int PHASE_W = 18;
    localparam int ASYM_W  = 16;
    localparam int K2PI_W  = 30;
    localparam logic [63:0] ONE_Q30         = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30     = 64'd1686629713;
    localparam logic [K2PI_W-1:0] TWO_OVER_PI_Q30 = 30'd683565276;
    localparam logic [ASYM_W-1:0] ASYM_Q16  = 16'd39322;
    localparam int TANH_SPAN_LOG2 = 3;

    typedef enum logic [1:0] {
        MODE_SOFT = 2'd0,
        MODE_HARD = 2'd1,
        MODE_FOLD = 2'd2,
        MODE_ASYM = 2'd3
    } t_mode;

    // per-beat control that travels with the data
    typedef struct packed {
        t_mode mode;
        logic  neg;
    } t_ctrl;

endpackage

@@ src/aws_front.sv @@
// ----------------------------------------------------------------------------
// aws_front
// magnitude and pre-gain, then asymmetric scale, sine phase and hard clip
// ----------------------------------------------------------------------------
module aws_front #(
    parameter int SAMPLE_BITS = aws_pkg::SAMPLE_BITS_DEF,
    localparam int MW = SAMPLE_BITS + 8
) (
    input  logic                          i_clk,
    input  logic                          i_en0,
    input  logic                          i_en1,
    input  logic [SAMPLE_BITS-1:0]        i_sample,
    input  aws_pkg::t_mode                i_mode,
    input  logic [aws_pkg::GAIN_W-1:0]    i_drive,
    output logic [MW-1:0]                 o_mag,
    output logic [aws_pkg::PHASE_W-1:0]   o_phase,
    output logic [SAMPLE_BITS-1:0]        o_hard,
    output aws_pkg::t_ctrl                o_ctrl
);
    localparam int FRAC = SAMPLE_BITS - 1;
    localparam int AW   = MW + aws_pkg::ASYM_W;
    localparam int SW   = MW + aws_pkg::K2PI_W;

    logic [SAMPLE_BITS-1:0]     n_xmag;
    logic [aws_pkg::GAIN_W-1:0] n_drive;
    logic [aws_pkg::GAIN_W-1:0] n_gain;
    logic [MW-1:0]              r_mag0;
    aws_pkg::t_ctrl             r_ctrl0;
    logic [AW-1:0]              n_asym;
    logic [SW-1:0]              n_sprod;
    logic [MW-1:0]              n_hard_w;
    logic [MW-1:0]              n_mag1;
    logic [SAMPLE_BITS-1:0]     n_hard;

    // stage 0: magnitude times 64 + drive
    always_comb begin
        n_xmag  = i_sample[SAMPLE_BITS-1] ? (~i_sample + 1'b1) : i_sample;
        n_drive = (i_drive > aws_pkg::DRIVE_MAX) ? aws_pkg::DRIVE_MAX : i_drive;
        n_gain  = aws_pkg::GAIN_BASE + n_drive;
    end

    always_ff @(posedge i_clk) begin
        if (i_en0) begin
            r_mag0       <= MW'(n_xmag) * MW'(n_gain);
            r_ctrl0.mode <= i_mode;
            r_ctrl0.neg  <= i_sample[SAMPLE_BITS-1];
        end
    end

    // stage 1: asymmetric scale, phase in quarter turns, hard clip
    always_comb begin
        n_asym  = AW'(r_mag0) * AW'(aws_pkg::ASYM_Q16) + AW'(32768);
        n_mag1  = (r_ctrl0.mode == aws_pkg::MODE_ASYM && r_ctrl0.neg)
                ? n_asym[AW-1:aws_pkg::ASYM_W] : r_mag0;
        n_sprod = SW'(r_mag0) * SW'(aws_pkg::TWO_OVER_PI_Q30);
        n_hard_w = (r_mag0 + MW'(32)) >> 6;
        n_hard  = (n_hard_w > (MW'(1) << FRAC))
                ? (SAMPLE_BITS'(1) << FRAC) : n_hard_w[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en1) begin
            o_mag   <= n_mag1;
            o_phase <= n_sprod[FRAC+20 +: aws_pkg::PHASE_W];
            o_hard  <= n_hard;
            o_ctrl  <= r_ctrl0;
        end
    end

endmodule

@@ src/aws_addr.sv @@
// ----------------------------------------------------------------------------
// aws_addr
// table position, neighbour indexes and interpolation fraction
// ----------------------------------------------------------------------------
module aws_addr #(
    parameter int SAMPLE_BITS = aws_pkg::SAMPLE_BITS_DEF,
    parameter int TABLE_DEPTH = aws_pkg::TABLE_DEPTH_DEF,
    localparam int MW = SAMPLE_BITS + 8,
    localparam int TW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [MW-1:0]                 i_mag,
    input  logic [aws_pkg::PHASE_W-1:0]   i_phase,
    input  logic [SAMPLE_BITS-1:0]        i_hard,
    input  aws_pkg::t_ctrl                i_ctrl,
    output logic [TW-1:0]                 o_idx_lo,
    output logic [TW-1:0]                 o_idx_hi,
    output logic [aws_pkg::FR_W-1:0]      o_frac,
    output logic [SAMPLE_BITS-1:0]        o_hard,
    output aws_pkg::t_ctrl                o_ctrl
);
    localparam int PW = MW + TW;
    localparam int TSHIFT = SAMPLE_BITS - 1 + 6 + aws_pkg::TANH_SPAN_LOG2 - aws_pkg::FR_W;

    logic                        n_fold;
    logic [aws_pkg::FR_W:0]      n_g;
    logic [PW-1:0]               n_tpos;
    logic [PW-1:0]               n_spos;
    logic [PW-1:0]               n_pos;
    logic [PW-aws_pkg::FR_W-1:0] n_idx_full;
    logic [TW-1:0]               n_idx_lo;
    logic [TW-1:0]               n_idx_hi;
    logic [aws_pkg::FR_W-1:0]    n_frac;
    aws_pkg::t_ctrl              n_ctrl;

    always_comb begin
        n_fold = (i_ctrl.mode == aws_pkg::MODE_FOLD);
        // odd quadrants run the quarter wave backwards
        n_g = i_phase[aws_pkg::FR_W]
            ? ((aws_pkg::FR_W+1)'(1) << aws_pkg::FR_W) - {1'b0, i_phase[aws_pkg::FR_W-1:0]}
            : {1'b0, i_phase[aws_pkg::FR_W-1:0]};
        n_tpos = (PW'(i_mag) * PW'(TABLE_DEPTH)) >> TSHIFT;
        n_spos = PW'(n_g) * PW'(TABLE_DEPTH);
        n_pos  = n_fold ? n_spos : n_tpos;
        n_idx_full = n_pos[PW-1:aws_pkg::FR_W];
        if (n_idx_full >= (PW-aws_pkg::FR_W)'(TABLE_DEPTH)) begin
            // past the table end: last entry, no interpolation
            n_idx_lo = TW'(TABLE_DEPTH);
            n_idx_hi = TW'(TABLE_DEPTH);
            n_frac   = '0;
        end else begin
            n_idx_lo = n_idx_full[TW-1:0];
            n_idx_hi = n_idx_full[TW-1:0] + 1'b1;
            n_frac   = n_pos[aws_pkg::FR_W-1:0];
        end
        n_ctrl = i_ctrl;
        // lower half turn of the sine flips the sign
        if (n_fold) begin
            n_ctrl.neg = i_ctrl.neg ^ i_phase[aws_pkg::FR_W+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_idx_lo <= n_idx_lo;
            o_idx_hi <= n_idx_hi;
            o_frac   <= n_frac;
            o_hard   <= i_hard;
            o_ctrl   <= n_ctrl;
        end
    end

endmodule

@@ src/aws_rom.sv @@
// ----------------------------------------------------------------------------
// aws_rom
// tanh and quarter-wave sine tables, both neighbours read, registered
// ----------------------------------------------------------------------------
module aws_rom #(
    parameter int SAMPLE_BITS = aws_pkg::SAMPLE_BITS_DEF,
    parameter int TABLE_DEPTH = aws_pkg::TABLE_DEPTH_DEF,
    localparam int TW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [TW-1:0]                 i_idx_lo,
    input  logic [TW-1:0]                 i_idx_hi,
    input  logic [aws_pkg::FR_W-1:0]      i_frac,
    input  logic [SAMPLE_BITS-1:0]        i_hard,
    input  aws_pkg::t_ctrl                i_ctrl,
    output logic [aws_pkg::Q30_W-1:0]     o_lo,
    output logic [aws_pkg::Q30_W-1:0]     o_hi,
    output logic [aws_pkg::FR_W-1:0]      o_frac,
    output logic [SAMPLE_BITS-1:0]        o_hard,
    output aws_pkg::t_ctrl                o_ctrl
);
    typedef logic [aws_pkg::Q30_W-1:0] t_tab [TABLE_DEPTH+1];

    function automatic logic [63:0] qmul30(input logic [63:0] a, input logic [63:0] b);
        return (a * b) >> 30;
    endfunction

    // shift and subtract quotient, table build only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo, rem;
        int          b;
        quo = '0;
        rem = '0;
        for (b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // tanh over [0, 8] by the addition formula from a series step
    function automatic t_tab tanh_table();
        t_tab        tab;
        logic [63:0] h, h2, p3, p5, p7, p9, thu, t;
        int          k;
        h   = (aws_pkg::ONE_Q30 << aws_pkg::TANH_SPAN_LOG2) / 64'(TABLE_DEPTH);
        h2  = qmul30(h, h);
        p3  = qmul30(h, h2);
        p5  = qmul30(p3, h2);
        p7  = qmul30(p5, h2);
        p9  = qmul30(p7, h2);
        thu = h - p3 / 3 + (2 * p5) / 15 - (17 * p7) / 315 + (62 * p9) / 2835;
        t   = '0;
        for (k = 0; k <= TABLE_DEPTH; k++) begin
            tab[k] = t[aws_pkg::Q30_W-1:0];
            t = udiv64((t + thu) << 30, aws_pkg::ONE_Q30 + qmul30(t, thu));
            if (t > aws_pkg::ONE_Q30) begin
                t = aws_pkg::ONE_Q30;
            end
        end
        return tab;
    endfunction

    // sine over [0, pi/2] by its taylor series
    function automatic t_tab sine_table();
        t_tab        tab;
        logic [63:0] x, x2, term;
        longint      sum;
        int          k, n;
        for (k = 0; k <= TABLE_DEPTH; k++) begin
            x    = (64'(k) * aws_pkg::HALF_PI_Q30) / 64'(TABLE_DEPTH);
            x2   = qmul30(x, x);
            term = x;
            sum  = longint'(x);
            for (n = 1; n <= 8; n++) begin
                term = udiv64(qmul30(term, x2), 64'((2 * n) * (2 * n + 1)));
                if (n % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > longint'(aws_pkg::ONE_Q30)) begin
                sum = longint'(aws_pkg::ONE_Q30);
            end
            tab[k] = aws_pkg::Q30_W'(sum);
        end
        return tab;
    endfunction

    localparam t_tab TANH_TAB = tanh_table();
    localparam t_tab SINE_TAB = sine_table();

    logic n_fold;

    assign n_fold = (i_ctrl.mode == aws_pkg::MODE_FOLD);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_lo   <= n_fold ? SINE_TAB[i_idx_lo] : TANH_TAB[i_idx_lo];
            o_hi   <= n_fold ? SINE_TAB[i_idx_hi] : TANH_TAB[i_idx_hi];
            o_frac <= i_frac;
            o_hard <= i_hard;
            o_ctrl <= i_ctrl;
        end
    end

endmodule

@@ src/aws_interp.sv @@
// ----------------------------------------------------------------------------
// aws_interp
// linear interpolation, rounding to the sample format, sign and saturation
// ----------------------------------------------------------------------------
module aws_interp #(
    parameter int SAMPLE_BITS = aws_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en0,
    input  logic                          i_en1,
    input  logic [aws_pkg::Q30_W-1:0]     i_lo,
    input  logic [aws_pkg::Q30_W-1:0]     i_hi,
    input  logic [aws_pkg::FR_W-1:0]      i_frac,
    input  logic [SAMPLE_BITS-1:0]        i_hard,
    input  aws_pkg::t_ctrl                i_ctrl,
    output logic [SAMPLE_BITS-1:0]        o_sample
);
    localparam int FRAC = SAMPLE_BITS - 1;
    localparam int QW   = aws_pkg::Q30_W;
    localparam int PRW  = QW + aws_pkg::FR_W;

    logic [QW-1:0]          n_diff;
    logic [PRW-1:0]         n_prod;
    logic [QW-1:0]          r_val;
    logic [SAMPLE_BITS-1:0] r_hard;
    aws_pkg::t_ctrl         r_ctrl;
    logic [QW-1:0]          n_rsum;
    logic [SAMPLE_BITS-1:0] n_res;
    logic [SAMPLE_BITS-1:0] n_one;

    // stage 4: lo + (hi - lo) * frac
    always_comb begin
        n_diff = (i_hi < i_lo) ? '0 : (i_hi - i_lo);
        n_prod = PRW'(n_diff) * PRW'(i_frac);
    end

    always_ff @(posedge i_clk) begin
        if (i_en0) begin
            r_val  <= i_lo + n_prod[PRW-1:aws_pkg::FR_W];
            r_hard <= i_hard;
            r_ctrl <= i_ctrl;
        end
    end

    // stage 5: round half up, limit to one, apply sign
    always_comb begin
        n_one  = SAMPLE_BITS'(1) << FRAC;
        n_rsum = r_val + (QW'(1) << (29 - FRAC));
        n_res  = (r_ctrl.mode == aws_pkg::MODE_HARD) ? r_hard : n_rsum[30:30-FRAC];
        if (n_res > n_one) begin
            n_res = n_one;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en1) begin
            if (r_ctrl.neg) begin
                o_sample <= ~n_res + 1'b1;
            end else begin
                o_sample <= (n_res > n_one - 1'b1) ? (n_one - 1'b1) : n_res;
            end
        end
    end

endmodule

@@ src/audio_waveshaper_four_mode_top.sv @@
// ----------------------------------------------------------------------------
// audio_waveshaper_four_mode_top
// four-curve waveshaper: pre-gain 1 + drive/64, then tanh, clip, sine or
// asymmetric tanh, one signed fractional sample in and one out
// ----------------------------------------------------------------------------
// usage
//   input channel: i_in_valid / o_in_stall with i_sample_in; a beat is taken
//   on a rising edge with valid high and stall low
//   output channel: o_out_valid / i_out_stall with o_sample_out, same rule
//   configuration: i_cfg_we with i_cfg_index (0 mode, 1 drive) and
//   i_cfg_data, written on the edge; the user must write only while the
//   pipe is empty, the block itself does not enforce it
//   throughput: one beat per cycle without output stall, six register stages
//   (gain, phase/scale, address, table read, interpolate, round)
//   a stall on the output holds the last stage; bubbles further up still
//   close, so input keeps flowing until every stage is full
//   reset: pipe emptied, mode back to sine fold, drive back to 141
//   tables are constant logic, no fill after reset
// ----------------------------------------------------------------------------
module audio_waveshaper_four_mode_top #(
    parameter int SAMPLE_BITS = aws_pkg::SAMPLE_BITS_DEF,
    parameter int TABLE_DEPTH = aws_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]    i_sample_in,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]    o_sample_out,
    input  logic                             i_cfg_we,
    input  logic [aws_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [aws_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    localparam int MW     = SAMPLE_BITS + 8;
    localparam int TW     = $clog2(TABLE_DEPTH + 1);
    localparam int STAGES = 6;

    // configuration registers
    aws_pkg::t_mode             r_mode;
    logic [aws_pkg::GAIN_W-1:0] r_drive;

    // per-stage valid bits and load enables
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_en;

    // data between stages
    logic [MW-1:0]                 w_mag;
    logic [aws_pkg::PHASE_W-1:0]   w_phase;
    logic [SAMPLE_BITS-1:0]        w_hard_a, w_hard_b, w_hard_c;
    aws_pkg::t_ctrl                w_ctrl_a, w_ctrl_b, w_ctrl_c;
    logic [TW-1:0]                 w_idx_lo, w_idx_hi;
    logic [aws_pkg::FR_W-1:0]      w_frac_b, w_frac_c;
    logic [aws_pkg::Q30_W-1:0]     w_lo, w_hi;
    logic [SAMPLE_BITS-1:0]        w_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= aws_pkg::MODE_FOLD;
            r_drive <= aws_pkg::DRIVE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                aws_pkg::CFG_MODE: begin
                    r_mode <= aws_pkg::t_mode'(i_cfg_data[1:0]);
                end
                aws_pkg::CFG_DRIVE: begin
                    r_drive <= i_cfg_data;
                end
            endcase
        end
    end

    // a stage loads when empty or when the stage after it moves on
    always_comb begin
        n_en[STAGES-1] = !r_vld[STAGES-1] || !i_out_stall;
        for (int k = STAGES - 2; k >= 0; k--) begin
            n_en[k] = !r_vld[k] || n_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (n_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_stall   = !n_en[0];
    assign o_out_valid  = r_vld[STAGES-1];
    assign o_sample_out = w_sample;

    // gain and phase/scale stages
    aws_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_en0    (n_en[0]),
        .i_en1    (n_en[1]),
        .i_sample (i_sample_in),
        .i_mode   (r_mode),
        .i_drive  (r_drive),
        .o_mag    (w_mag),
        .o_phase  (w_phase),
        .o_hard   (w_hard_a),
        .o_ctrl   (w_ctrl_a)
    );

    // table address stage
    aws_addr #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_addr (
        .i_clk    (i_clk),
        .i_en     (n_en[2]),
        .i_mag    (w_mag),
        .i_phase  (w_phase),
        .i_hard   (w_hard_a),
        .i_ctrl   (w_ctrl_a),
        .o_idx_lo (w_idx_lo),
        .o_idx_hi (w_idx_hi),
        .o_frac   (w_frac_b),
        .o_hard   (w_hard_b),
        .o_ctrl   (w_ctrl_b)
    );

    // table read stage
    aws_rom #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_rom (
        .i_clk    (i_clk),
        .i_en     (n_en[3]),
        .i_idx_lo (w_idx_lo),
        .i_idx_hi (w_idx_hi),
        .i_frac   (w_frac_b),
        .i_hard   (w_hard_b),
        .i_ctrl   (w_ctrl_b),
        .o_lo     (w_lo),
        .o_hi     (w_hi),
        .o_frac   (w_frac_c),
        .o_hard   (w_hard_c),
        .o_ctrl   (w_ctrl_c)
    );

    // interpolation and output stages; the last one is the output register
    aws_interp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_interp (
        .i_clk    (i_clk),
        .i_en0    (n_en[4]),
        .i_en1    (n_en[5]),
        .i_lo     (w_lo),
        .i_hi     (w_hi),
        .i_frac   (w_frac_c),
        .i_hard   (w_hard_c),
        .i_ctrl   (w_ctrl_c),
        .o_sample (w_sample)
    );

endmodule
